// ===== design/fbfl_pkg.sv =====
// Package with the shared widths, codes and divider channel types of the block pool allocator.
`timescale 1ns / 1ps

package fbfl_pkg;

	localparam int NUM_BLOCKS = 1024;

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int LINK_W = $clog2(NUM_BLOCKS + 1);

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 32;
	localparam int BLK_W = 16;
	localparam int FIELD_IDX_W = 10;
	localparam int ACT_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DIV_STEPS = SIZE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_BLOCKS);

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_ADDRESS = 2'd0,
		CFG_BUFFER_SIZE  = 2'd1,
		CFG_BLOCK_SIZE   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic              start;
		logic [SIZE_W-1:0] dividend;
		logic [BLK_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SIZE_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== design/fixed_block_free_list_allocator.sv =====
// Top level of the fixed-size block pool allocator with its free-list link memory.
`timescale 1ns / 1ps

// The pool hands out fixed-size blocks of one buffer from a free list held in a
// single-port link memory with a registered read port. A free, an unused
// action or an allocation from an empty list completes straight from idle,
// and a granted allocation goes on through S_ALLOC, waiting on the link
// memory read of the head entry. An init with a nonzero block size runs the
// bit-serial division of the buffer size by the block size, then one link
// memory write per block; with a zero block size it completes from idle.
// Results sit in an output register, so the next transfer is accepted while a
// result waits to be taken.
module fixed_block_free_list_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [fbfl_pkg::ACT_W-1:0]       action,
	input  logic [fbfl_pkg::FIELD_IDX_W-1:0] block_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             ok,
	output logic [fbfl_pkg::FIELD_IDX_W-1:0] given_index,
	output logic [fbfl_pkg::ADDR_W-1:0]      given_address,
	input  logic                             wr_en,
	input  logic [fbfl_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [fbfl_pkg::CFG_DATA_W-1:0]  wr_data
);
	import fbfl_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ALLOC = 5'b00010,
		S_DIV   = 5'b00100,
		S_LINK  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] buf_size_q;
	logic [BLK_W-1:0]  blk_size_q;

	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] total_q;
	logic [LINK_W-1:0] link_cnt_q;

	logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
	logic [LINK_W-1:0] rd_data_q;

	logic [IDX_W-1:0]        blk_q;
	logic [IDX_W+BLK_W-1:0]  prod_s1;

	logic                   res_ok_q;
	logic [FIELD_IDX_W-1:0] res_idx_q;
	logic [ADDR_W-1:0]      res_addr_q;

	logic                   out_valid_q;
	logic                   out_ok_q;
	logic [FIELD_IDX_W-1:0] out_idx_q;
	logic [ADDR_W-1:0]      out_addr_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                   accept;
	logic [SIZE_W-1:0]      idx_ext;
	logic                   idx_in_range;
	logic                   slot_free;
	logic                   fin;
	logic                   fin_ok;
	logic [FIELD_IDX_W-1:0] fin_idx;
	logic [ADDR_W-1:0]      fin_addr;
	logic                   out_load;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [LINK_W-1:0]      mem_wdata;
	logic                   mem_re;
	logic [IDX_W-1:0]       mem_raddr;
	logic [LINK_W-1:0]      sat_total;

	fbfl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign idx_ext = SIZE_W'(block_index);
	assign idx_in_range = (idx_ext < SIZE_W'(NUM_BLOCKS));
	assign slot_free = !out_valid_q || out_ready;
	assign sat_total = (div_rsp.quotient > SIZE_W'(NUM_BLOCKS)) ? LINK_W'(NUM_BLOCKS)
		: LINK_W'(div_rsp.quotient);

	always_comb begin
		fin = 1'b0;
		fin_ok = 1'b1;
		fin_idx = '0;
		fin_addr = '0;
		mem_we = 1'b0;
		mem_waddr = link_cnt_q[IDX_W-1:0];
		mem_wdata = head_q;
		mem_re = 1'b0;
		mem_raddr = head_q[IDX_W-1:0];
		div_req.start = 1'b0;
		div_req.dividend = buf_size_q;
		div_req.divisor = blk_size_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_ALLOC: begin
							if (head_q != NULL_LINK) begin
								mem_re = 1'b1;
							end else begin
								fin = 1'b1;
								fin_ok = 1'b0;
							end
						end
						ACT_FREE: begin
							fin = 1'b1;
							mem_we = idx_in_range;
							mem_waddr = IDX_W'(idx_ext);
						end
						ACT_INIT: begin
							div_req.start = (blk_size_q != '0);
							fin = (blk_size_q == '0);
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				fin = 1'b1;
				fin_idx = FIELD_IDX_W'(blk_q);
				fin_addr = base_q + ADDR_W'(prod_s1);
			end
			S_LINK: begin
				if (link_cnt_q == total_q) begin
					fin = 1'b1;
				end else begin
					mem_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
		out_load = (fin || (state_q == S_OUT)) && slot_free;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= link_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= NULL_LINK;
			total_q <= '0;
			link_cnt_q <= '0;
			out_valid_q <= 1'b0;
			base_q <= '0;
			buf_size_q <= '0;
			blk_size_q <= BLK_W'(64);
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_BASE_ADDRESS: base_q <= wr_data[ADDR_W-1:0];
					CFG_BUFFER_SIZE:  buf_size_q <= wr_data[SIZE_W-1:0];
					CFG_BLOCK_SIZE:   blk_size_q <= wr_data[BLK_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_ALLOC: begin
								if (head_q != NULL_LINK) begin
									state_q <= S_ALLOC;
								end else if (!slot_free) begin
									state_q <= S_OUT;
								end
							end
							ACT_FREE: begin
								if (idx_in_range) begin
									head_q <= LINK_W'(idx_ext);
								end
								if (!slot_free) begin
									state_q <= S_OUT;
								end
							end
							ACT_INIT: begin
								head_q <= NULL_LINK;
								if (blk_size_q == '0) begin
									total_q <= '0;
									if (!slot_free) begin
										state_q <= S_OUT;
									end
								end else begin
									state_q <= S_DIV;
								end
							end
							default: begin
								if (!slot_free) begin
									state_q <= S_OUT;
								end
							end
						endcase
					end
				end
				S_ALLOC: begin
					head_q <= rd_data_q;
					state_q <= slot_free ? S_IDLE : S_OUT;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						total_q <= sat_total;
						link_cnt_q <= '0;
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (link_cnt_q == total_q) begin
						state_q <= slot_free ? S_IDLE : S_OUT;
					end else begin
						head_q <= link_cnt_q;
						link_cnt_q <= link_cnt_q + 1'b1;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= head_q[IDX_W-1:0];
			prod_s1 <= head_q[IDX_W-1:0] * blk_size_q;
		end
		if (fin) begin
			res_ok_q <= fin_ok;
			res_idx_q <= fin_idx;
			res_addr_q <= fin_addr;
		end
		if (out_load) begin
			if (state_q == S_OUT) begin
				out_ok_q <= res_ok_q;
				out_idx_q <= res_idx_q;
				out_addr_q <= res_addr_q;
			end else begin
				out_ok_q <= fin_ok;
				out_idx_q <= fin_idx;
				out_addr_q <= fin_addr;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ok = out_ok_q;
	assign given_index = out_idx_q;
	assign given_address = out_addr_q;

endmodule

// ===== design/fbfl_div.sv =====
// Radix-2 restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps

module fbfl_div (
	input  logic            clk,
	input  logic            arst_n,
	input  fbfl_pkg::div_req_t req,
	output fbfl_pkg::div_rsp_t rsp
);
	import fbfl_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BLK_W-1:0]     rem_q;
	logic [SIZE_W-1:0]    quo_q;
	logic [BLK_W-1:0]     div_q;

	logic [BLK_W:0] trial;
	logic [BLK_W:0] diff;
	logic           fits;

	always_comb begin
		trial = {rem_q, quo_q[SIZE_W-1]};
		diff = trial - {1'b0, div_q};
		fits = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[BLK_W-1:0] : trial[BLK_W-1:0];
			quo_q <= {quo_q[SIZE_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule
